>>> rtl/pbsc_pkg.sv
// Package: shared types, constants and timeout table for the power button shutdown controller.
`timescale 1ns / 1ps

package pbsc_pkg;

    localparam int unsigned TICK_MS    = 10;
    localparam int unsigned IDLE_W     = 21;
    localparam int unsigned RETRY_W    = 16;
    localparam int unsigned MODE_W     = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_RETRY    = 2'd1;

    // Shutdown modes
    localparam logic [MODE_W-1:0] MODE_OFF_PRESSED = 4'd0;
    localparam logic [MODE_W-1:0] MODE_ALWAYS_ON   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_TOGGLE      = 4'd2;
    localparam logic [MODE_W-1:0] MODE_TO_10S      = 4'd3;
    localparam logic [MODE_W-1:0] MODE_TO_1M       = 4'd4;
    localparam logic [MODE_W-1:0] MODE_TO_5M       = 4'd5;
    localparam logic [MODE_W-1:0] MODE_TO_10M      = 4'd6;
    localparam logic [MODE_W-1:0] MODE_TO_30M      = 4'd7;
    localparam logic [MODE_W-1:0] MODE_TO_1H       = 4'd8;
    localparam logic [MODE_W-1:0] MODE_TO_5H       = 4'd9;

    localparam logic [MODE_W-1:0]  RST_SHUTDOWN_MODE = MODE_TOGGLE;
    localparam logic [RETRY_W-1:0] RST_GATE_RETRY    = 16'd200;

    // Seconds to ticks, rounded up
    localparam longint unsigned RAW_TICKS_10S =
        (64'd10 * 64'd1000 + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
    localparam longint unsigned RAW_TICKS_1M =
        (64'd60 * 64'd1000 + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
    localparam longint unsigned RAW_TICKS_5M =
        (64'd300 * 64'd1000 + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
    localparam longint unsigned RAW_TICKS_10M =
        (64'd600 * 64'd1000 + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
    localparam longint unsigned RAW_TICKS_30M =
        (64'd1800 * 64'd1000 + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
    localparam longint unsigned RAW_TICKS_1H =
        (64'd3600 * 64'd1000 + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
    localparam longint unsigned RAW_TICKS_5H =
        (64'd18000 * 64'd1000 + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);

    // Clamp to the saturated idle count so that the count still reaches it
    function automatic logic [IDLE_W-1:0] clamp_ticks(input longint unsigned t);
        logic [IDLE_W-1:0] c;
        if (t > 64'(IDLE_MAX)) begin
            c = IDLE_MAX;
        end else begin
            c = t[IDLE_W-1:0];
        end
        return c;
    endfunction

    localparam logic [IDLE_W-1:0] TO_TICKS_10S = clamp_ticks(RAW_TICKS_10S);
    localparam logic [IDLE_W-1:0] TO_TICKS_1M  = clamp_ticks(RAW_TICKS_1M);
    localparam logic [IDLE_W-1:0] TO_TICKS_5M  = clamp_ticks(RAW_TICKS_5M);
    localparam logic [IDLE_W-1:0] TO_TICKS_10M = clamp_ticks(RAW_TICKS_10M);
    localparam logic [IDLE_W-1:0] TO_TICKS_30M = clamp_ticks(RAW_TICKS_30M);
    localparam logic [IDLE_W-1:0] TO_TICKS_1H  = clamp_ticks(RAW_TICKS_1H);
    localparam logic [IDLE_W-1:0] TO_TICKS_5H  = clamp_ticks(RAW_TICKS_5H);

    function automatic logic [IDLE_W-1:0] timeout_ticks(input logic [MODE_W-1:0] mode);
        logic [IDLE_W-1:0] t;
        unique case (mode)
            MODE_TO_10S: t = TO_TICKS_10S;
            MODE_TO_1M:  t = TO_TICKS_1M;
            MODE_TO_5M:  t = TO_TICKS_5M;
            MODE_TO_10M: t = TO_TICKS_10M;
            MODE_TO_30M: t = TO_TICKS_30M;
            MODE_TO_1H:  t = TO_TICKS_1H;
            MODE_TO_5H:  t = TO_TICKS_5H;
            default:     t = '0;
        endcase
        return t;
    endfunction

    typedef struct packed {
        logic button_sample;
        logic activity_reset;
        logic sampling_off;
    } t_tick_req;

    typedef struct packed {
        logic              shutdown_now;
        logic              gate_enable;
        logic              hold_on;
        logic              pressed;
        logic [IDLE_W-1:0] idle_ticks;
    } t_tick_res;

endpackage

>>> rtl/pbsc_step.sv
// Controller state and the per-tick next-state and result logic.
`timescale 1ns / 1ps

module pbsc_step
    import pbsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  t_tick_req          i_req,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [RETRY_W-1:0] i_retry,
    output t_tick_res          o_res
);

    logic               r_last_pressed, n_last_pressed;
    logic               r_gates_off,    n_gates_off;
    logic [RETRY_W-1:0] r_gate_off_cnt, n_gate_off_cnt;
    logic [IDLE_W-1:0]  r_idle,         n_idle;

    logic [IDLE_W-1:0]  idle_base;
    logic [IDLE_W-1:0]  idle_inc;
    logic [RETRY_W:0]   retry_next;
    logic               clicked;
    logic               gates_mid;
    logic               sd;
    logic               ge;
    logic               hold;

    always_comb begin
        n_last_pressed = r_last_pressed;
        n_gates_off    = r_gates_off;
        n_gate_off_cnt = r_gate_off_cnt;
        n_idle         = r_idle;
        sd             = 1'b0;
        ge             = 1'b0;
        hold           = 1'b0;
        idle_base      = i_req.activity_reset ? '0 : r_idle;
        idle_inc       = (idle_base < IDLE_MAX) ? idle_base + 1'b1 : idle_base;
        retry_next     = {1'b0, r_gate_off_cnt} + 1'b1;
        clicked        = r_last_pressed & ~i_req.button_sample;
        gates_mid      = r_gates_off;

        if (!i_req.sampling_off) begin
            n_last_pressed = i_req.button_sample;
            priority if (i_mode == MODE_OFF_PRESSED) begin
                if (i_req.button_sample) begin
                    sd        = 1'b1;
                    gates_mid = 1'b1;
                end
            end else if (i_mode == MODE_ALWAYS_ON) begin
                hold = 1'b1;
            end else if (clicked) begin
                sd        = 1'b1;
                gates_mid = 1'b1;
            end

            n_gates_off = gates_mid;
            if (gates_mid && i_req.button_sample) begin
                if (retry_next > {1'b0, i_retry}) begin
                    ge             = 1'b1;
                    n_gates_off    = 1'b0;
                    n_gate_off_cnt = '0;
                end else begin
                    n_gate_off_cnt = retry_next[RETRY_W-1:0];
                end
            end

            if (i_mode >= MODE_TO_10S) begin
                n_idle = idle_inc;
                if (idle_inc >= timeout_ticks(i_mode) && i_req.button_sample) begin
                    sd          = 1'b1;
                    n_gates_off = 1'b1;
                end
            end else begin
                n_idle = '0;
            end
        end

        o_res.shutdown_now = sd;
        o_res.gate_enable  = ge;
        o_res.hold_on      = hold;
        o_res.pressed      = n_last_pressed;
        o_res.idle_ticks   = n_idle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pressed <= 1'b0;
            r_gates_off    <= 1'b0;
            r_gate_off_cnt <= '0;
            r_idle         <= '0;
        end else if (i_fire) begin
            r_last_pressed <= n_last_pressed;
            r_gates_off    <= n_gates_off;
            r_gate_off_cnt <= n_gate_off_cnt;
            r_idle         <= n_idle;
        end
    end

endmodule

>>> rtl/power_button_shutdown_controller_unit.sv
// Top level: request register, configuration registers and result register.
`timescale 1ns / 1ps

// Power button shutdown controller.
// Input channel (i_valid / o_ready) carries one tick request per sampling
// tick: the button level, an activity reset and a sampling-off flag.
// Output channel (o_valid / i_ready) returns exactly one result per request:
// shutdown, gate re-enable and hold flags, the stored button level and the
// saturating inactivity count.
// Configuration: i_cfg_wr_en writes i_cfg_wdata into register i_cfg_index
// (0 shutdown mode, 1 gate retry ticks) in the same cycle; write only while
// no request is in flight.
// Pipeline: two register stages (request register, then result register); the
// request register accepts the request, and the result register loads when it
// moves on, which a stalled receiver can hold off. Throughput: one request per
// cycle while the receiver takes results; the result register fed by a single
// pass of compare/increment logic sets that rate.
// When the receiver stalls, the result register holds and the request
// register fills; o_ready drops only when both are occupied.
// Reset (synchronous, active low) empties both stages, clears the button,
// gate and inactivity state and loads the default mode and retry time.

module power_button_shutdown_controller_unit
    import pbsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_button_sample,
    input  logic                  i_activity_reset,
    input  logic                  i_sampling_off,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_shutdown_now,
    output logic                  o_gate_enable,
    output logic                  o_hold_on,
    output logic                  o_pressed,
    output logic [IDLE_W-1:0]     o_idle_ticks,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [MODE_W-1:0]  r_mode;
    logic [RETRY_W-1:0] r_retry;

    logic      r_s1_valid;
    t_tick_req r_s1_req;
    logic      r_out_valid;
    t_tick_res r_out;

    logic      out_ready;
    logic      s1_ready;
    logic      s1_fire;
    t_tick_res step_res;

    // Configuration registers: index decode, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RST_SHUTDOWN_MODE;
            r_retry <= RST_GATE_RETRY;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SHUTDOWN_MODE: r_mode  <= i_cfg_wdata[MODE_W-1:0];
                CFG_GATE_RETRY:    r_retry <= i_cfg_wdata[RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance when the result register is free or being drained
    assign out_ready = !r_out_valid || i_ready;
    assign s1_fire   = r_s1_valid && out_ready;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign o_ready   = s1_ready;

    // Request register: capture a new request whenever the stage moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_s1_req.button_sample  <= i_button_sample;
            r_s1_req.activity_reset <= i_activity_reset;
            r_s1_req.sampling_off   <= i_sampling_off;
        end
    end

    // State update and result logic; state commits when the request moves on
    pbsc_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_req   (r_s1_req),
        .i_mode  (r_mode),
        .i_retry (r_retry),
        .o_res   (step_res)
    );

    // Result register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= step_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_shutdown_now = r_out.shutdown_now;
    assign o_gate_enable  = r_out.gate_enable;
    assign o_hold_on      = r_out.hold_on;
    assign o_pressed      = r_out.pressed;
    assign o_idle_ticks   = r_out.idle_ticks;

    // A request leaving the first stage always lands in the result register
    a_s1_to_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_valid)
        else $error("request lost between stages");

    // Always-on mode never requests a shutdown on the same tick
    a_hold_no_sd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(o_hold_on && o_shutdown_now))
        else $error("hold and shutdown on one tick");

    // Gate retry fires only while the button is held
    a_ge_pressed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_gate_enable) |-> o_pressed)
        else $error("gate re-enabled with button released");

    // A sampling-off request raises no flag and leaves the stored button level alone
    a_off_keeps : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_req.sampling_off) |->
            (!step_res.shutdown_now && !step_res.gate_enable && !step_res.hold_on
             && (step_res.pressed == u_step.r_last_pressed)))
        else $error("sampling-off tick changed state");

endmodule
